@@ src/bmm_pkg.sv @@
package bmm_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 6;

    localparam logic [CfgIdxW-1:0] CFG_RAM_PAGE_MASK = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DISK_IF = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DISK_ROMS = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_MULTI_PLANE = 2'd3;

    localparam logic [2:0] MODE_READ = 3'd0;
    localparam logic [2:0] MODE_LATCH_A = 3'd1;
    localparam logic [2:0] MODE_LATCH_B = 3'd2;
    localparam logic [2:0] MODE_SESSION = 3'd3;
    localparam logic [2:0] MODE_TRIGGER = 3'd4;
    localparam logic [2:0] MODE_QUADRANT = 3'd5;

    localparam logic [1:0] ROLE_BASIC128 = 2'd0;
    localparam logic [1:0] ROLE_BASIC48 = 2'd1;
    localparam logic [1:0] ROLE_SERVICE = 2'd2;
    localparam logic [1:0] ROLE_DISK = 2'd3;

    localparam logic [15:0] STROBE_MASK = 16'hFFF3;
    localparam logic [15:0] STROBE_ADDR = 16'h0100;
    localparam logic [15:0] HIGH_CODE_ADDR = 16'h4000;

    localparam logic [5:0] RAM_PAGE_MASK_RST = 6'd15;

    typedef struct packed {
        logic [5:0] ram_page_mask;
        logic       disk_if;
        logic       disk_roms;
        logic       multi_plane;
    } t_cfg;

    typedef struct packed {
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic       session;
        logic       trigger;
        logic [4:0] quadrant;
    } t_state;

    typedef struct packed {
        logic       is_ram;
        logic [6:0] rom_page;
        logic [5:0] top;
        logic       ports;
        logic       leave;
        logic       trap;
        logic       window;
    } t_map;

    function automatic t_map map_of(input t_state s, input t_cfg c);
        t_map       m;
        logic [1:0] role;
        logic [6:0] base;
        m.top = {s.latch_b[7:6], s.latch_b[4], s.latch_a[2:0]} & c.ram_page_mask;
        base = c.multi_plane ? {s.quadrant, 2'b00} : 7'd0;
        m.is_ram = 1'b0;
        if (s.trigger && c.disk_roms) begin
            role = s.latch_b[1] ? ROLE_SERVICE : ROLE_DISK;
        end else if (s.latch_b[0]) begin
            role = ROLE_BASIC128;
            m.is_ram = 1'b1;
        end else if (s.latch_b[1]) begin
            role = ROLE_SERVICE;
        end else if (s.session) begin
            role = ROLE_DISK;
        end else if (s.latch_a[4]) begin
            role = ROLE_BASIC48;
        end else begin
            role = ROLE_BASIC128;
        end
        m.rom_page = m.is_ram ? 7'd0 : (base | {5'd0, role});
        m.ports = 1'b0;
        m.leave = 1'b0;
        m.trap = 1'b0;
        if (s.session && c.disk_roms) begin
            m.ports = 1'b1;
            m.leave = 1'b1;
        end else if (s.trigger && c.disk_roms) begin
            m.ports = 1'b1;
        end else if (!s.latch_b[0] && (s.latch_b[1] || s.latch_a[4])
                     && c.disk_if && c.disk_roms) begin
            m.trap = 1'b1;
        end
        m.window = c.multi_plane && !m.is_ram && (role == ROLE_SERVICE);
        return m;
    endfunction

endpackage

@@ src/bmm_cfg.sv @@
module bmm_cfg
    import bmm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RAM_PAGE_MASK: n_cfg.ram_page_mask = i_cfg_data;
                CFG_DISK_IF:       n_cfg.disk_if = i_cfg_data[0];
                CFG_DISK_ROMS:     n_cfg.disk_roms = i_cfg_data[0];
                CFG_MULTI_PLANE:   n_cfg.multi_plane = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_page_mask <= RAM_PAGE_MASK_RST;
            r_cfg.disk_if <= 1'b1;
            r_cfg.disk_roms <= 1'b1;
            r_cfg.multi_plane <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/bmm_core.sv @@
module bmm_core
    import bmm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_addr,
    input  logic        i_is_fetch,
    input  logic [7:0]  i_value,
    input  t_cfg        i_cfg,
    output t_map        o_map,
    output logic        o_hit
);

    t_state r_state;
    t_state n_state;
    t_map   cur_map;
    logic   is_read;

    assign cur_map = map_of(r_state, i_cfg);
    assign is_read = (i_mode == MODE_READ);

    always_comb begin
        n_state = r_state;
        case (i_mode)
            MODE_READ: begin
                if (r_state.trigger && i_is_fetch && (i_addr >= HIGH_CODE_ADDR)) begin
                    n_state.trigger = 1'b0;
                end
            end
            MODE_LATCH_A:  n_state.latch_a = i_value;
            MODE_LATCH_B:  n_state.latch_b = i_value;
            MODE_SESSION:  n_state.session = i_value[0];
            MODE_TRIGGER:  n_state.trigger = i_value[0];
            MODE_QUADRANT: n_state.quadrant = i_value[4:0];
            default:       n_state = r_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_map = map_of(n_state, i_cfg);
    assign o_hit = is_read && cur_map.window && !i_is_fetch
                   && ((i_addr & STROBE_MASK) == STROBE_ADDR);

endmodule

@@ src/banked_memory_mapper_unit.sv @@
// channel   valid          stall          payload
// input     i_in_valid     o_in_stall     i_mode i_addr i_is_fetch i_value
// output    o_out_valid    i_out_stall    o_low_bank_* o_top_ram_page o_disk_* o_strobe_*
// config    i_cfg_we       (none)         i_cfg_idx i_cfg_data
//
// One transaction per cycle is sustained unless a stalled result holds the pipeline.
// Stage one is the input register, stage two updates the paging state and the result register.
// Synchronous active-low reset clears valids and paging state, loads register defaults.
// A stalled result holds the result and a full input register; o_in_stall rises only when
// the input register is full and cannot advance.
module banked_memory_mapper_unit
    import bmm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_mode,
    input  logic [15:0]         i_addr,
    input  logic                i_is_fetch,
    input  logic [7:0]          i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_low_bank_is_ram,
    output logic [6:0]          o_low_bank_rom_page,
    output logic [5:0]          o_top_ram_page,
    output logic                o_disk_ports_on,
    output logic                o_leave_disk_on_ram,
    output logic                o_disk_rom_trap_armed,
    output logic                o_strobe_window_open,
    output logic                o_strobe_hit
);

    t_cfg        cfg;
    t_map        map;
    logic        hit;
    logic        advance;
    logic        fire;
    logic        in_take;

    logic        r_in_valid;
    logic [2:0]  r_mode;
    logic [15:0] r_addr;
    logic        r_is_fetch;
    logic [7:0]  r_value;

    logic        r_out_valid;
    t_map        r_map;
    logic        r_hit;

    assign advance = !r_out_valid || !i_out_stall;
    assign fire = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take = i_in_valid && !o_in_stall;

    bmm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bmm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_mode     (r_mode),
        .i_addr     (r_addr),
        .i_is_fetch (r_is_fetch),
        .i_value    (r_value),
        .i_cfg      (cfg),
        .o_map      (map),
        .o_hit      (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode <= i_mode;
            r_addr <= i_addr;
            r_is_fetch <= i_is_fetch;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_map <= map;
            r_hit <= hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_low_bank_is_ram = r_map.is_ram;
    assign o_low_bank_rom_page = r_map.rom_page;
    assign o_top_ram_page = r_map.top;
    assign o_disk_ports_on = r_map.ports;
    assign o_leave_disk_on_ram = r_map.leave;
    assign o_disk_rom_trap_armed = r_map.trap;
    assign o_strobe_window_open = r_map.window;
    assign o_strobe_hit = r_hit;

endmodule

@@ dv/bmm_mapping_checker.sv @@
`timescale 1ns / 100ps

module bmm_mapping_checker
    import bmm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic [2:0]          i_mode,
    input  logic [15:0]         i_addr,
    input  logic                i_is_fetch,
    input  logic [7:0]          i_value,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic                o_low_bank_is_ram,
    input  logic [6:0]          o_low_bank_rom_page,
    input  logic [5:0]          o_top_ram_page,
    input  logic                o_disk_ports_on,
    input  logic                o_leave_disk_on_ram,
    input  logic                o_disk_rom_trap_armed,
    input  logic                o_strobe_window_open,
    input  logic                o_strobe_hit,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int PagesPerQuadrant = 4;
    localparam int RoleRam = -1;

    typedef struct packed {
        logic       is_ram;
        logic [6:0] rom_page;
        logic [5:0] top;
        logic       ports;
        logic       leave;
        logic       trap;
        logic       window;
        logic       hit;
    } mapping_t;

    logic [5:0] page_mask;
    logic       disk_if;
    logic       disk_roms;
    logic       multi_plane;

    logic [7:0] lat_a;
    logic [7:0] lat_b;
    logic       session;
    logic       trigger;
    logic [4:0] quadrant;

    mapping_t expected_maps[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic mapping_t current_mapping();
        mapping_t   m;
        int         role;
        logic [7:0] page_bits;
        logic [6:0] base;
        m = '0;
        page_bits = (lat_a & 8'h07) | ((lat_b & 8'h10) >> 1) | ((lat_b & 8'hC0) >> 2);
        m.top = page_bits[5:0] & page_mask;
        base = multi_plane ? 7'(int'(quadrant) * PagesPerQuadrant) : 7'd0;
        if (trigger && disk_roms) begin
            role = lat_b[1] ? int'(ROLE_SERVICE) : int'(ROLE_DISK);
        end else if (lat_b[0]) begin
            role = RoleRam;
            m.is_ram = 1'b1;
        end else if (lat_b[1]) begin
            role = int'(ROLE_SERVICE);
        end else if (session) begin
            role = int'(ROLE_DISK);
        end else if (lat_a[4]) begin
            role = int'(ROLE_BASIC48);
        end else begin
            role = int'(ROLE_BASIC128);
        end
        m.rom_page = (role == RoleRam) ? 7'd0 : 7'(int'(base) + role);
        if (session && disk_roms) begin
            m.ports = 1'b1;
            m.leave = 1'b1;
        end else if (trigger && disk_roms) begin
            m.ports = 1'b1;
        end else if (!lat_b[0] && (lat_b[1] || lat_a[4]) && disk_if && disk_roms) begin
            m.trap = 1'b1;
        end
        m.window = multi_plane && (role == int'(ROLE_SERVICE));
        return m;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("mapping mismatch on %s: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        mapping_t pre;
        mapping_t want;
        logic     hit;
        if (!i_rst_n) begin
            page_mask = RAM_PAGE_MASK_RST;
            disk_if = 1'b1;
            disk_roms = 1'b1;
            multi_plane = 1'b0;
            lat_a = '0;
            lat_b = '0;
            session = 1'b0;
            trigger = 1'b0;
            quadrant = '0;
            expected_maps.delete();
            o_pending = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_maps.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = expected_maps.pop_front();
                    check_field("low_bank_is_ram", want.is_ram, o_low_bank_is_ram);
                    check_field("low_bank_rom_page", want.rom_page, o_low_bank_rom_page);
                    check_field("top_ram_page", want.top, o_top_ram_page);
                    check_field("disk_ports_on", want.ports, o_disk_ports_on);
                    check_field("leave_disk_on_ram", want.leave, o_leave_disk_on_ram);
                    check_field("disk_rom_trap_armed", want.trap, o_disk_rom_trap_armed);
                    check_field("strobe_window_open", want.window, o_strobe_window_open);
                    check_field("strobe_hit", want.hit, o_strobe_hit);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAM_PAGE_MASK: page_mask = i_cfg_data[5:0];
                    CFG_DISK_IF:       disk_if = i_cfg_data[0];
                    CFG_DISK_ROMS:     disk_roms = i_cfg_data[0];
                    CFG_MULTI_PLANE:   multi_plane = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                hit = 1'b0;
                case (i_mode)
                    MODE_READ: begin
                        pre = current_mapping();
                        hit = pre.window && !i_is_fetch
                              && ((i_addr & STROBE_MASK) == STROBE_ADDR);
                        if (trigger && i_is_fetch && (i_addr >= HIGH_CODE_ADDR)) begin
                            trigger = 1'b0;
                        end
                    end
                    MODE_LATCH_A:  lat_a = i_value;
                    MODE_LATCH_B:  lat_b = i_value;
                    MODE_SESSION:  session = i_value[0];
                    MODE_TRIGGER:  trigger = i_value[0];
                    MODE_QUADRANT: quadrant = i_value[4:0];
                    default: ;
                endcase
                want = current_mapping();
                want.hit = hit;
                expected_maps.push_back(want);
            end
            o_pending = expected_maps.size();
        end
    end

endmodule

@@ dv/tb_banked_memory_mapper_unit.sv @@
`timescale 1ns / 100ps

module tb_banked_memory_mapper_unit;
    import bmm_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int PhaseItems = 70;
    localparam int NumPhases = 6;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [2:0]          i_mode;
    logic [15:0]         i_addr;
    logic                i_is_fetch;
    logic [7:0]          i_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_low_bank_is_ram;
    logic [6:0]          o_low_bank_rom_page;
    logic [5:0]          o_top_ram_page;
    logic                o_disk_ports_on;
    logic                o_leave_disk_on_ram;
    logic                o_disk_rom_trap_armed;
    logic                o_strobe_window_open;
    logic                o_strobe_hit;

    int fail_count;
    int pending;
    bit idle_on;
    int stall_left;

    banked_memory_mapper_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_mode                (i_mode),
        .i_addr                (i_addr),
        .i_is_fetch            (i_is_fetch),
        .i_value               (i_value),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_low_bank_is_ram     (o_low_bank_is_ram),
        .o_low_bank_rom_page   (o_low_bank_rom_page),
        .o_top_ram_page        (o_top_ram_page),
        .o_disk_ports_on       (o_disk_ports_on),
        .o_leave_disk_on_ram   (o_leave_disk_on_ram),
        .o_disk_rom_trap_armed (o_disk_rom_trap_armed),
        .o_strobe_window_open  (o_strobe_window_open),
        .o_strobe_hit          (o_strobe_hit)
    );

    bmm_mapping_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_mode                (i_mode),
        .i_addr                (i_addr),
        .i_is_fetch            (i_is_fetch),
        .i_value               (i_value),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_low_bank_is_ram     (o_low_bank_is_ram),
        .o_low_bank_rom_page   (o_low_bank_rom_page),
        .o_top_ram_page        (o_top_ram_page),
        .o_disk_ports_on       (o_disk_ports_on),
        .o_leave_disk_on_ram   (o_leave_disk_on_ram),
        .o_disk_rom_trap_armed (o_disk_rom_trap_armed),
        .o_strobe_window_open  (o_strobe_window_open),
        .o_strobe_hit          (o_strobe_hit),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send(input logic [2:0] mode, input logic [15:0] addr,
                        input logic fetch, input logic [7:0] value);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode = mode;
        i_addr = addr;
        i_is_fetch = fetch;
        i_value = value;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int          pick;
        logic [2:0]  mode;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 45)      mode = MODE_READ;
        else if (pick < 55) mode = MODE_LATCH_A;
        else if (pick < 70) mode = MODE_LATCH_B;
        else if (pick < 77) mode = MODE_SESSION;
        else if (pick < 85) mode = MODE_TRIGGER;
        else if (pick < 95) mode = MODE_QUADRANT;
        else                mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
        case ($urandom_range(0, 3))
            0: addr = STROBE_ADDR | (16'($urandom) & ~STROBE_MASK);
            1: addr = HIGH_CODE_ADDR - 16'd2 + 16'($urandom_range(0, 3));
            default: addr = 16'($urandom);
        endcase
        send(mode, addr, 1'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = CfgDataW'(data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input int mask, input int dif, input int roms, input int mp);
        drain();
        write_reg(CFG_RAM_PAGE_MASK, mask);
        write_reg(CFG_DISK_IF, dif);
        write_reg(CFG_DISK_ROMS, roms);
        write_reg(CFG_MULTI_PLANE, mp);
    endtask

    initial begin
        stall_left = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            i_out_stall = (stall_left > 0);
        end
    end

    initial begin
        #2_000_000;
        $display("tb_banked_memory_mapper_unit: FAIL");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = MODE_READ;
        i_addr = '0;
        i_is_fetch = 1'b0;
        i_value = '0;
        idle_on = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset mapping, latch extremes, priority chain, spare modes
        send(MODE_READ, 16'h0000, 1'b0, 8'h00);
        send(MODE_LATCH_A, 16'hFFFF, 1'b1, 8'hFF);
        send(MODE_LATCH_B, 16'hFFFF, 1'b1, 8'hFF);
        send(MODE_LATCH_B, 16'h0000, 1'b0, 8'h00);
        send(MODE_LATCH_A, 16'h0000, 1'b0, 8'h10);
        send(MODE_SESSION, 16'h0000, 1'b0, 8'hFF);
        send(MODE_SESSION, 16'h0000, 1'b0, 8'hFE);
        send(MODE_SPARE_LO, 16'h0100, 1'b0, 8'hFF);
        send(MODE_SPARE_HI, 16'h4000, 1'b1, 8'hFF);

        // strobe window and trigger release on a multi-plane ROM
        configure(63, 1, 1, 1);
        send(MODE_QUADRANT, 16'h0000, 1'b0, 8'hFF);
        send(MODE_LATCH_B, 16'h0000, 1'b0, 8'h02);
        send(MODE_READ, 16'h0100, 1'b0, 8'h00);
        send(MODE_READ, 16'h010C, 1'b0, 8'h00);
        send(MODE_READ, 16'h0100, 1'b1, 8'h00);
        send(MODE_READ, 16'h0110, 1'b0, 8'h00);
        send(MODE_TRIGGER, 16'h0000, 1'b0, 8'h01);
        send(MODE_LATCH_B, 16'h0000, 1'b0, 8'h00);
        send(MODE_READ, 16'h3FFF, 1'b1, 8'h00);
        send(MODE_READ, 16'hFFFF, 1'b1, 8'h00);
        send(MODE_TRIGGER, 16'h0000, 1'b0, 8'hFF);
        send(MODE_LATCH_B, 16'h0000, 1'b0, 8'h03);
        send(MODE_READ, 16'h0104, 1'b0, 8'h00);
        send(MODE_READ, 16'h4000, 1'b1, 8'h00);

        for (int phase = 0; phase < NumPhases; phase++) begin
            case (phase)
                0: configure(63, 1, 1, 1);
                1: configure(0, 0, 1, 1);
                2: configure(15, 1, 0, 1);
                3: configure(42, 1, 1, 0);
                4: configure(63, 0, 0, 0);
                default: begin
                    configure($urandom_range(0, 63), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                    idle_on = 1'b0;
                end
            endcase
            repeat (PhaseItems) send_random();
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_banked_memory_mapper_unit: PASS");
        end else begin
            $display("tb_banked_memory_mapper_unit: FAIL");
        end
        $finish;
    end

endmodule
